@@ hdl/lhezc_pkg.sv @@
package lhezc_pkg;

    // Field and register widths fixed by the block's function
    localparam int PosW      = 16;
    localparam int ZoneW     = 2;
    localparam int PhaseW    = 3;
    localparam int LongW     = 12;
    localparam int CfgDataW  = 16;
    localparam int CfgIdxW   = 1;
    // Common width for timer-versus-threshold compares (timer width is at most 16)
    localparam int TickCmpW  = 16;

    // Default parameter values
    localparam int CountWidthDef = 32;
    localparam int TimerWidthDef = 12;

    // Register reset values
    localparam logic [PosW-1:0]  LimitReset     = 16'd30840;
    localparam logic [LongW-1:0] LongPressReset = 12'd2000;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_LIMIT      = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_LONG_PRESS = 1'd1;

    // Calibration phases
    localparam logic [PhaseW-1:0] PH_IDLE            = 3'd0;
    localparam logic [PhaseW-1:0] PH_STARTED         = 3'd1;
    localparam logic [PhaseW-1:0] PH_SET_LOWER       = 3'd2;
    localparam logic [PhaseW-1:0] PH_LOWER_SET       = 3'd3;
    localparam logic [PhaseW-1:0] PH_SET_LOWER_COLOR = 3'd4;
    localparam logic [PhaseW-1:0] PH_LOWER_COLOR_SET = 3'd5;
    localparam logic [PhaseW-1:0] PH_SET_UPPER_COLOR = 3'd6;
    localparam logic [PhaseW-1:0] PH_UPPER_SET       = 3'd7;

    // Zone codes
    localparam logic [ZoneW-1:0] ZONE_GREEN  = 2'd0;
    localparam logic [ZoneW-1:0] ZONE_YELLOW = 2'd1;
    localparam logic [ZoneW-1:0] ZONE_RED    = 2'd2;

    // One registered input sample
    typedef struct packed {
        logic chan_a;
        logic chan_b;
        logic button_down;
        logic ms_tick;
    } sample_t;

    // One result
    typedef struct packed {
        logic [PosW-1:0]   clamped_position;
        logic [ZoneW-1:0]  zone;
        logic              calibrating;
        logic [PhaseW-1:0] calib_phase;
        logic              position_changed;
        logic              encoder_error;
    } result_t;

endpackage

@@ hdl/lhezc_in_if.sv @@
interface lhezc_in_if;
    logic valid;
    logic ready;
    logic chan_a;
    logic chan_b;
    logic button_down;
    logic ms_tick;

    modport source (output valid, chan_a, chan_b, button_down, ms_tick, input ready);
    modport sink   (input valid, chan_a, chan_b, button_down, ms_tick, output ready);
endinterface

@@ hdl/lhezc_out_if.sv @@
interface lhezc_out_if;
    logic                            valid;
    logic                            ready;
    logic [lhezc_pkg::PosW-1:0]      clamped_position;
    logic [lhezc_pkg::ZoneW-1:0]     zone;
    logic                            calibrating;
    logic [lhezc_pkg::PhaseW-1:0]    calib_phase;
    logic                            position_changed;
    logic                            encoder_error;

    modport source (output valid, clamped_position, zone, calibrating, calib_phase,
                    position_changed, encoder_error, input ready);
    modport sink   (input valid, clamped_position, zone, calibrating, calib_phase,
                    position_changed, encoder_error, output ready);
endinterface

@@ hdl/lhezc_core.sv @@
module lhezc_core #(
    parameter int COUNT_WIDTH = lhezc_pkg::CountWidthDef,
    parameter int TIMER_WIDTH = lhezc_pkg::TimerWidthDef
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  lhezc_pkg::sample_t             sample,
    input  logic [lhezc_pkg::PosW-1:0]     limit_pulses,
    input  logic [lhezc_pkg::LongW-1:0]    long_press_ticks,
    output lhezc_pkg::result_t             result
);

    localparam logic [COUNT_WIDTH-1:0] CountMax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic [COUNT_WIDTH-1:0] CountMin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam logic [TIMER_WIDTH-1:0] TimerMax = {TIMER_WIDTH{1'b1}};

    logic                           prev_a_reg, prev_b_reg;
    logic [COUNT_WIDTH-1:0]         raw_count_reg, raw_count_next;
    logic [COUNT_WIDTH-1:0]         prev_raw_reg;
    logic [lhezc_pkg::PhaseW-1:0]   phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0]         hold_reg, hold_next;
    logic [TIMER_WIDTH-1:0]         press_reg, press_next;
    logic                           press_seen_reg, press_seen_next;
    logic [lhezc_pkg::PosW-1:0]     lower_reg, lower_next;
    logic [lhezc_pkg::PosW-1:0]     upper_reg, upper_next;

    logic                           ch_a, ch_b;
    logic                           dir_up, dir_dn;
    logic [COUNT_WIDTH-1:0]         count_upd;
    logic [lhezc_pkg::PosW-1:0]     pos;
    logic [lhezc_pkg::ZoneW-1:0]    zone;
    logic [TIMER_WIDTH-1:0]         hold_inc, press_inc;
    logic [lhezc_pkg::TickCmpW-1:0] long_cmp;
    logic                           short_release;

    // Quadrature decode
    assign ch_a   = sample.chan_a != prev_a_reg;
    assign ch_b   = sample.chan_b != prev_b_reg;
    assign dir_up = (ch_a && !ch_b && (sample.chan_a == sample.chan_b))
                 || (ch_b && !ch_a && (sample.chan_a != sample.chan_b));
    assign dir_dn = (ch_a && !ch_b && (sample.chan_a != sample.chan_b))
                 || (ch_b && !ch_a && (sample.chan_a == sample.chan_b));

    // Saturating count update
    always_comb
    begin
        count_upd = raw_count_reg;
        if (dir_up && raw_count_reg != CountMax)
            count_upd = raw_count_reg + COUNT_WIDTH'(1);
        else if (dir_dn && raw_count_reg != CountMin)
            count_upd = raw_count_reg - COUNT_WIDTH'(1);
    end

    // Clamp and zone
    always_comb
    begin
        if (count_upd[COUNT_WIDTH-1])
            pos = '0;
        else if (count_upd > COUNT_WIDTH'(limit_pulses))
            pos = limit_pulses;
        else
            pos = lhezc_pkg::PosW'(count_upd);

        if (pos > upper_reg)
            zone = lhezc_pkg::ZONE_RED;
        else if (pos < lower_reg)
            zone = lhezc_pkg::ZONE_YELLOW;
        else
            zone = lhezc_pkg::ZONE_GREEN;
    end

    // Tick timers, saturating
    assign long_cmp  = lhezc_pkg::TickCmpW'(long_press_ticks);
    assign hold_inc  = (sample.ms_tick && hold_reg != TimerMax)
                     ? hold_reg + TIMER_WIDTH'(1) : hold_reg;
    assign press_inc = (sample.ms_tick && press_reg != TimerMax)
                     ? press_reg + TIMER_WIDTH'(1) : press_reg;

    // Press detector shared by the capture phases
    always_comb
    begin
        press_seen_next = press_seen_reg;
        press_next      = press_reg;
        short_release   = 1'b0;
        if (sample.button_down && !press_seen_reg)
        begin
            press_seen_next = 1'b1;
            press_next      = '0;
        end
        else if (press_seen_reg)
        begin
            press_next = press_inc;
            if (!sample.button_down)
            begin
                press_seen_next = 1'b0;
                short_release   = lhezc_pkg::TickCmpW'(press_inc) <= long_cmp;
            end
        end
    end

    // Calibration sequencer
    always_comb
    begin
        phase_next     = phase_reg;
        hold_next      = hold_reg;
        raw_count_next = count_upd;
        lower_next     = lower_reg;
        upper_next     = upper_reg;
        unique case (phase_reg) inside
            lhezc_pkg::PH_IDLE:
            begin
                if (sample.button_down)
                begin
                    if (lhezc_pkg::TickCmpW'(hold_inc) > long_cmp)
                    begin
                        hold_next  = '0;
                        phase_next = lhezc_pkg::PH_STARTED;
                    end
                    else
                        hold_next = hold_inc;
                end
                else
                    hold_next = '0;
            end
            lhezc_pkg::PH_STARTED:
            begin
                if (!sample.button_down)
                    phase_next = lhezc_pkg::PH_SET_LOWER;
            end
            lhezc_pkg::PH_SET_LOWER:
            begin
                if (short_release)
                begin
                    raw_count_next = '0;
                    phase_next     = lhezc_pkg::PH_LOWER_SET;
                end
            end
            lhezc_pkg::PH_SET_LOWER_COLOR:
            begin
                if (short_release)
                begin
                    lower_next = pos;
                    phase_next = lhezc_pkg::PH_LOWER_COLOR_SET;
                end
            end
            lhezc_pkg::PH_SET_UPPER_COLOR:
            begin
                if (short_release)
                begin
                    upper_next = pos;
                    phase_next = lhezc_pkg::PH_UPPER_SET;
                end
            end
            lhezc_pkg::PH_UPPER_SET:
                phase_next = lhezc_pkg::PH_IDLE;
            lhezc_pkg::PH_LOWER_SET, lhezc_pkg::PH_LOWER_COLOR_SET:
                phase_next = phase_reg + lhezc_pkg::PhaseW'(1);
            default:
                phase_next = lhezc_pkg::PH_IDLE;
        endcase
    end

    // Press timer only runs in the capture phases
    logic capture_phase;
    assign capture_phase = (phase_reg == lhezc_pkg::PH_SET_LOWER)
                        || (phase_reg == lhezc_pkg::PH_SET_LOWER_COLOR)
                        || (phase_reg == lhezc_pkg::PH_SET_UPPER_COLOR);

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg     <= 1'b0;
            prev_b_reg     <= 1'b0;
            raw_count_reg  <= '0;
            prev_raw_reg   <= '0;
            phase_reg      <= lhezc_pkg::PH_IDLE;
            hold_reg       <= '0;
            press_reg      <= '0;
            press_seen_reg <= 1'b0;
            lower_reg      <= '0;
            upper_reg      <= '0;
        end
        else if (step)
        begin
            prev_a_reg    <= sample.chan_a;
            prev_b_reg    <= sample.chan_b;
            raw_count_reg <= raw_count_next;
            prev_raw_reg  <= count_upd;
            phase_reg     <= phase_next;
            hold_reg      <= hold_next;
            lower_reg     <= lower_next;
            upper_reg     <= upper_next;
            if (capture_phase)
            begin
                press_reg      <= press_next;
                press_seen_reg <= press_seen_next;
            end
        end
    end

    // Result for this sample
    always_comb
    begin
        result.clamped_position = pos;
        result.zone             = zone;
        result.calibrating      = phase_next != lhezc_pkg::PH_IDLE;
        result.calib_phase      = phase_next;
        result.position_changed = count_upd != prev_raw_reg;
        result.encoder_error    = ch_a && ch_b;
    end

endmodule

@@ hdl/lift_height_encoder_zone_calibrator.sv @@
// Lift height encoder with zone classification and button-driven calibration.
// in  : one request per sample of encoder A/B, set button and a 1 ms tick flag.
// out : one result per sample: clamped position (pulses, 0.005 mm each),
//       zone, calibration phase, change flag and double-edge error flag.
// cfg : write cfg_we with cfg_index 0 (limit_pulses) or 1 (long_press_ticks);
//       write only while no sample is in flight.
// Throughput is one sample per cycle while out.ready is high. A sample is
// taken into the input register, the count/phase logic runs combinationally
// from that register and the result register then loads from it when the
// sample advances. The state update (count, timers, phase) is registered in
// the same cycle as the result, which is what sets the one-sample-per-cycle rate.
// When out.ready is low the result register holds its value; the input
// register still takes one more sample, then in.ready drops until the
// result is taken. Reset clears the count, thresholds, timers and phase
// and loads limit_pulses = 30840 and long_press_ticks = 2000.
module lift_height_encoder_zone_calibrator #(
    parameter int COUNT_WIDTH = lhezc_pkg::CountWidthDef,
    parameter int TIMER_WIDTH = lhezc_pkg::TimerWidthDef
) (
    input  logic                            clk,
    input  logic                            rst_n,
    lhezc_in_if.sink                        in,
    lhezc_out_if.source                     out,
    input  logic                            cfg_we,
    input  logic [lhezc_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [lhezc_pkg::CfgDataW-1:0]  cfg_data
);

    logic [lhezc_pkg::PosW-1:0]  limit_reg;
    logic [lhezc_pkg::LongW-1:0] long_press_reg;

    logic                 in_vld_reg;
    lhezc_pkg::sample_t   sample_reg;
    logic                 out_vld_reg;
    lhezc_pkg::result_t   result_reg;
    lhezc_pkg::result_t   result_next;
    logic                 advance;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg      <= lhezc_pkg::LimitReset;
            long_press_reg <= lhezc_pkg::LongPressReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lhezc_pkg::REG_LIMIT:
                    limit_reg <= cfg_data;
                lhezc_pkg::REG_LONG_PRESS:
                    long_press_reg <= lhezc_pkg::LongW'(cfg_data);
                default:
                    limit_reg <= limit_reg;
            endcase
        end
    end

    // Pipeline control
    assign advance  = in_vld_reg && (!out_vld_reg || out.ready);
    assign in.ready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in.valid && in.ready)
                in_vld_reg <= 1'b1;
            else if (advance)
                in_vld_reg <= 1'b0;

            if (advance)
                out_vld_reg <= 1'b1;
            else if (out.ready)
                out_vld_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in.valid && in.ready)
        begin
            sample_reg.chan_a      <= in.chan_a;
            sample_reg.chan_b      <= in.chan_b;
            sample_reg.button_down <= in.button_down;
            sample_reg.ms_tick     <= in.ms_tick;
        end
        if (advance)
            result_reg <= result_next;
    end

    lhezc_core #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .sample           (sample_reg),
        .limit_pulses     (limit_reg),
        .long_press_ticks (long_press_reg),
        .result           (result_next)
    );

    // Output channel
    assign out.valid            = out_vld_reg;
    assign out.clamped_position = result_reg.clamped_position;
    assign out.zone             = result_reg.zone;
    assign out.calibrating      = result_reg.calibrating;
    assign out.calib_phase      = result_reg.calib_phase;
    assign out.position_changed = result_reg.position_changed;
    assign out.encoder_error    = result_reg.encoder_error;

    // Checks
    a_calib_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (result_reg.calibrating == (result_reg.calib_phase != lhezc_pkg::PH_IDLE)))
        else $error("calibrating flag disagrees with phase");

    a_zone_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (result_reg.zone != 2'd3))
        else $error("invalid zone code");

    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg |-> (result_reg.clamped_position <= limit_reg))
        else $error("position above limit");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !advance) |=> in_vld_reg)
        else $error("stalled sample dropped");

endmodule
